>>> rtl/mrt_pkg.sv
// Package for the marked range table: operation codes, sequencer states,
// and sizing constants. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package mrt_pkg;
   localparam int TABLE_DEPTH_DEF = 32;
   localparam logic [15:0] CLEAN_MARK = 16'hFFFF;

   localparam logic [3:0] OP_INSERT  = 4'd0;
   localparam logic [3:0] OP_DELETE  = 4'd1;
   localparam logic [3:0] OP_ADD     = 4'd2;
   localparam logic [3:0] OP_NEXT    = 4'd3;
   localparam logic [3:0] OP_EXACT   = 4'd4;
   localparam logic [3:0] OP_OVERLAP = 4'd5;
   localparam logic [3:0] OP_DIRTY   = 4'd6;
   localparam logic [3:0] OP_CLEAN   = 4'd7;
   localparam logic [3:0] OP_ALL     = 4'd8;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD,      // issue read of slot i
      ST_EVAL,    // evaluate the read word
      ST_SHUP_RD, // read slot j-1 while opening a hole
      ST_SHUP_WR, // write it to slot j
      ST_SHDN_RD, // read slot j+1 while closing a hole
      ST_SHDN_WR, // write it to slot j
      ST_ALL_RD,  // read the last slot for the whole-table widen
      ST_ALL_EV,
      ST_DONE
   } state_type;
endpackage
`default_nettype wire

>>> rtl/mrt_store.sv
// Range storage for the marked range table: one memory of start and end
// pairs, one write port and one registered read port. Uses no package.
`timescale 1ns / 1ps
`default_nettype none
module mrt_store #(
   parameter int DEPTH = 32,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [AW-1:0] wr_addr,
   input  wire logic [15:0]   wr_start,
   input  wire logic [15:0]   wr_end,
   input  wire logic [AW-1:0] rd_addr,
   output logic      [15:0]   rd_start,
   output logic      [15:0]   rd_end
);
   logic [31:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= {wr_start, wr_end};
      end
      {rd_start, rd_end} <= mem[rd_addr];
   end
endmodule
`default_nettype wire

>>> rtl/marked_range_table.sv
// Marked range table: a sorted table of position ranges and a dirty window.
// Queries read and evaluate the visited slots one by one; opening or closing a hole shifts the
// tail one slot at a time, with a read state and then a write state per slot. Window-only
// operations skip the table walk.
// Throughput: one operation at a time; the next word is taken after the result is accepted.
// Reset (synchronous, active high) empties the table and sets the window to 0..65535.
`timescale 1ns / 1ps
`default_nettype none
module marked_range_table #(
   parameter int TABLE_DEPTH = mrt_pkg::TABLE_DEPTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [3:0]  req_operation,
   input  wire logic [15:0] req_position,
   input  wire logic [15:0] req_length,
   input  wire logic [15:0] req_range_end,
   input  wire logic        req_at_separator,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_found,
   output logic [15:0]      rsp_found_start,
   output logic [15:0]      rsp_found_end,
   output logic             rsp_window_clean,
   output logic [15:0]      rsp_dirty_start,
   output logic [15:0]      rsp_dirty_end,
   output logic             rsp_overflow
);
   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

   mrt_pkg::state_type state_ff, state_in;

   // Latched request word.
   logic [3:0]  op_ff, op_in;
   logic [15:0] pos_ff, pos_in, len_ff, len_in, rend_ff, rend_in;
   logic        sep_ff, sep_in;

   // Table and window state.
   logic [CW-1:0] count_ff, count_in;
   logic [15:0]   ws_ff, ws_in, we_ff, we_in;

   // Walk state: slot index, pass bound, hole index and pending write.
   logic [CW-1:0] i_ff, i_in, n_ff, n_in, j_ff, j_in;
   logic [15:0]   hs_ff, hs_in, he_ff, he_in;   // pair to place at the hole
   logic          found_ff, found_in, ovf_ff, ovf_in;
   logic [15:0]   fs_ff, fs_in, fe_ff, fe_in;
   logic [15:0]   first_ff, first_in;           // start of slot 0 for op 8

   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [15:0]   wr_s, wr_e, rd_s, rd_e;

   mrt_store #(.DEPTH(TABLE_DEPTH)) u_store (
      .clock, .wr_en, .wr_addr, .wr_start(wr_s), .wr_end(wr_e),
      .rd_addr, .rd_start(rd_s), .rd_end(rd_e)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mrt_pkg::ST_IDLE;
         count_ff <= '0;
         ws_ff    <= 16'h0000;
         we_ff    <= 16'hFFFF;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ws_ff    <= ws_in;
         we_ff    <= we_in;
      end
      op_ff <= op_in; pos_ff <= pos_in; len_ff <= len_in;
      rend_ff <= rend_in; sep_ff <= sep_in;
      i_ff <= i_in; n_ff <= n_in; j_ff <= j_in;
      hs_ff <= hs_in; he_ff <= he_in;
      found_ff <= found_in; ovf_ff <= ovf_in;
      fs_ff <= fs_in; fe_ff <= fe_in; first_ff <= first_in;
   end

   logic [15:0] endp, s, e;
   logic        full;

   always_comb begin
      state_in = state_ff;
      op_in = op_ff; pos_in = pos_ff; len_in = len_ff;
      rend_in = rend_ff; sep_in = sep_ff;
      count_in = count_ff; ws_in = ws_ff; we_in = we_ff;
      i_in = i_ff; n_in = n_ff; j_in = j_ff;
      hs_in = hs_ff; he_in = he_ff;
      found_in = found_ff; ovf_in = ovf_ff;
      fs_in = fs_ff; fe_in = fe_ff; first_in = first_ff;
      wr_en = 1'b0; wr_addr = i_ff[AW-1:0]; wr_s = '0; wr_e = '0;
      rd_addr = i_ff[AW-1:0];
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      endp = pos_ff + len_ff;
      s = rd_s; e = rd_e;
      full = (count_ff >= DEPTH_C);

      case (state_ff)
         mrt_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            rd_addr = '0;
            if (req_valid) begin
               op_in = req_operation; pos_in = req_position; len_in = req_length;
               rend_in = req_range_end; sep_in = req_at_separator;
               i_in = '0; n_in = count_ff;
               found_in = 1'b0; ovf_in = 1'b0; fs_in = '0; fe_in = '0;
               state_in = mrt_pkg::ST_RD;
               case (req_operation)
                  mrt_pkg::OP_INSERT: begin
                     if (ws_ff == mrt_pkg::CLEAN_MARK) begin
                        ws_in = req_position;
                        we_in = req_position + req_length;
                     end else begin
                        if (ws_ff > req_position) ws_in = req_position;
                        we_in = (we_ff >= req_position) ? we_ff + req_length
                                                        : req_position + req_length;
                     end
                  end
                  mrt_pkg::OP_DELETE: begin
                     if (ws_ff == mrt_pkg::CLEAN_MARK) begin
                        ws_in = (req_position != 16'd0) ? req_position - 16'd1 : 16'd0;
                        we_in = ((req_position != 16'd0) ? req_position - 16'd1
                                                         : 16'd0) + 16'd1;
                     end else begin
                        if (ws_ff > req_position) ws_in = req_position;
                        if (we_ff > req_position)
                           we_in = (we_ff > req_position + req_length)
                                   ? we_ff - req_length : req_position + 16'd1;
                     end
                  end
                  mrt_pkg::OP_DIRTY: begin
                     if (ws_ff == mrt_pkg::CLEAN_MARK || ws_ff > req_position)
                        ws_in = req_position;
                     if (we_ff < req_range_end) we_in = req_range_end;
                     state_in = mrt_pkg::ST_DONE;
                  end
                  mrt_pkg::OP_CLEAN: begin
                     ws_in = mrt_pkg::CLEAN_MARK;
                     we_in = 16'd0;
                     state_in = mrt_pkg::ST_DONE;
                  end
                  mrt_pkg::OP_ALL: begin
                     state_in = (count_ff != '0) ? mrt_pkg::ST_RD : mrt_pkg::ST_DONE;
                  end
                  mrt_pkg::OP_ADD, mrt_pkg::OP_NEXT, mrt_pkg::OP_EXACT,
                  mrt_pkg::OP_OVERLAP: ;
                  default: state_in = mrt_pkg::ST_DONE;
               endcase
            end
         end

         mrt_pkg::ST_RD: begin
            // Read issued at i; pass end checks happen here.
            if (op_ff == mrt_pkg::OP_INSERT ? (i_ff >= n_ff) : (i_ff >= count_ff)) begin
               if (op_ff == mrt_pkg::OP_ADD) begin
                  // Append at the end; the hole is the slot just past the last range.
                  if (full) begin
                     ovf_in = 1'b1; state_in = mrt_pkg::ST_DONE;
                  end else begin
                     hs_in = pos_ff; he_in = rend_ff; j_in = count_ff;
                     i_in = i_ff + CW'(1);
                     state_in = mrt_pkg::ST_SHUP_RD;
                  end
               end else begin
                  state_in = mrt_pkg::ST_DONE;
               end
            end else begin
               state_in = mrt_pkg::ST_EVAL;
            end
         end

         mrt_pkg::ST_EVAL: begin
            state_in = mrt_pkg::ST_RD;
            i_in = i_ff + CW'(1);
            case (op_ff)
               mrt_pkg::OP_INSERT: begin
                  if (e >= pos_ff) begin
                     if (s > pos_ff) begin
                        s = s + len_ff; e = e + len_ff;
                     end else if (e == pos_ff) begin
                        if (!sep_ff) e = e + len_ff;
                     end else if (s < pos_ff && e > pos_ff) begin
                        e = e + len_ff;
                        if (sep_ff) begin
                           // Split: the tail is written at slot i and shifted up to i+1; the front piece goes in at i.
                           if (full) begin
                              ovf_in = 1'b1;
                              s = pos_ff + 16'd1;
                           end else begin
                              hs_in = s; he_in = pos_ff;
                              j_in = count_ff;
                              s = pos_ff + 16'd1;
                              state_in = mrt_pkg::ST_SHUP_RD;
                           end
                        end
                     end else if (s == pos_ff) begin
                        e = e + len_ff;
                        if (sep_ff) s = s + 16'd1;
                     end
                  end
                  wr_en = 1'b1; wr_s = s; wr_e = e;
               end
               mrt_pkg::OP_DELETE: begin
                  if (e >= pos_ff) begin
                     if (s >= endp) begin
                        s = s - len_ff; e = e - len_ff;
                     end else if (s >= pos_ff && e <= endp) begin
                        j_in = i_ff; i_in = i_ff;
                        state_in = mrt_pkg::ST_SHDN_RD;
                     end else if (s <= pos_ff && e > pos_ff) begin
                        e = (e <= endp) ? pos_ff : e - len_ff;
                     end else if (s >= pos_ff && e > endp) begin
                        s = endp - len_ff; e = e - len_ff;
                     end
                  end
                  wr_en = (state_in == mrt_pkg::ST_RD);
                  wr_s = s; wr_e = e;
               end
               mrt_pkg::OP_ADD: begin
                  if (s >= pos_ff) begin
                     if (s == pos_ff && e > rend_ff) begin
                        wr_en = 1'b1; wr_s = rend_ff + 16'd1; wr_e = e;
                     end
                     if (full) begin
                        ovf_in = 1'b1; state_in = mrt_pkg::ST_DONE;
                     end else begin
                        hs_in = pos_ff; he_in = rend_ff; j_in = count_ff;
                        state_in = mrt_pkg::ST_SHUP_RD;
                     end
                  end
               end
               mrt_pkg::OP_NEXT: begin
                  if (e > pos_ff) begin
                     found_in = 1'b1; fs_in = s; fe_in = e;
                     state_in = mrt_pkg::ST_DONE;
                  end
               end
               mrt_pkg::OP_EXACT: begin
                  if (s == pos_ff && e == rend_ff) begin
                     found_in = 1'b1; state_in = mrt_pkg::ST_DONE;
                  end else if (s >= pos_ff) begin
                     state_in = mrt_pkg::ST_DONE;
                  end
               end
               mrt_pkg::OP_OVERLAP: begin
                  if (e >= pos_ff && s < rend_ff) begin
                     found_in = 1'b1; state_in = mrt_pkg::ST_DONE;
                  end else if (s >= rend_ff) begin
                     state_in = mrt_pkg::ST_DONE;
                  end
               end
               mrt_pkg::OP_ALL: begin
                  first_in = s;
                  i_in = count_ff - CW'(1);
                  state_in = mrt_pkg::ST_ALL_RD;
               end
               default: state_in = mrt_pkg::ST_DONE;
            endcase
         end

         // Opening a hole at the slot before i_ff: move j-1 to j downward.
         mrt_pkg::ST_SHUP_RD: begin
            rd_addr = AW'(j_ff - CW'(1));
            // The hole is always at i_ff-1. Once it is filled, an insert pass
            // steps over the tail piece of the split and resumes one slot later.
            if (j_ff == i_ff - CW'(1)) begin
               wr_en = 1'b1; wr_addr = AW'(j_ff); wr_s = hs_ff; wr_e = he_ff;
               count_in = count_ff + CW'(1);
               i_in = i_ff + CW'(1);
               state_in = (op_ff == mrt_pkg::OP_ADD) ? mrt_pkg::ST_DONE
                                                     : mrt_pkg::ST_RD;
            end else begin
               state_in = mrt_pkg::ST_SHUP_WR;
            end
         end
         mrt_pkg::ST_SHUP_WR: begin
            wr_en = 1'b1; wr_addr = AW'(j_ff); wr_s = rd_s; wr_e = rd_e;
            j_in = j_ff - CW'(1);
            state_in = mrt_pkg::ST_SHUP_RD;
         end

         // Closing the hole at j: move j+1 to j until the end.
         mrt_pkg::ST_SHDN_RD: begin
            rd_addr = AW'(j_ff + CW'(1));
            if (j_ff + CW'(1) >= count_ff) begin
               count_in = count_ff - CW'(1);
               state_in = mrt_pkg::ST_RD;
            end else begin
               state_in = mrt_pkg::ST_SHDN_WR;
            end
         end
         mrt_pkg::ST_SHDN_WR: begin
            wr_en = 1'b1; wr_addr = AW'(j_ff); wr_s = rd_s; wr_e = rd_e;
            j_in = j_ff + CW'(1);
            state_in = mrt_pkg::ST_SHDN_RD;
         end

         mrt_pkg::ST_ALL_RD: begin
            state_in = mrt_pkg::ST_ALL_EV;
         end
         mrt_pkg::ST_ALL_EV: begin
            if (ws_ff == mrt_pkg::CLEAN_MARK || ws_ff > first_ff) ws_in = first_ff;
            if (we_ff < rd_e) we_in = rd_e;
            state_in = mrt_pkg::ST_DONE;
         end

         mrt_pkg::ST_DONE: begin
            rsp_valid = 1'b1;
            if (rsp_ready) state_in = mrt_pkg::ST_IDLE;
         end
         default: state_in = mrt_pkg::ST_IDLE;
      endcase
   end

   // For an add, EVAL advanced i by one, so the hole is the slot just evaluated.
   // A split does the same, and the pass skips the tail piece after the hole is filled.

   assign rsp_found        = found_ff;
   assign rsp_found_start  = fs_ff;
   assign rsp_found_end    = fe_ff;
   assign rsp_window_clean = (ws_ff == mrt_pkg::CLEAN_MARK);
   assign rsp_dirty_start  = ws_ff;
   assign rsp_dirty_end    = we_ff;
   assign rsp_overflow     = ovf_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_C) else $error("range count beyond depth");
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("ready while a word is shown");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_dirty_start))
      else $error("result word changed while stalled");
endmodule
`default_nettype wire
